>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, masked while arst_n is low
`define BTPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition that must never be seen
`define BTPA_ASSERT_NEVER(lbl, cond, msg) \
	`BTPA_ASSERT(lbl, !(cond), msg)

`endif

>>> hdl/btpa_pkg.sv
`default_nettype none

package btpa_pkg;

	localparam int POOL_BYTES  = 65536;
	localparam int MAX_BLOCKS  = 32;
	localparam int ALIGN_LOG2  = 2;
	localparam int ALIGN_BYTES = 1 << ALIGN_LOG2;

	localparam int OP_W     = 2;
	localparam int SIZE_W   = 17;
	localparam int OFF_W    = 16;
	localparam int STATUS_W = 3;
	localparam int KIND_W   = 3;

	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [OP_W-1:0] OP_ALLOC = OP_W'(0);
	localparam logic [OP_W-1:0] OP_FREE  = OP_W'(1);
	localparam logic [OP_W-1:0] OP_CLEAR = OP_W'(2);

	localparam logic [KIND_W-1:0] KIND_ALLOC     = KIND_W'(0);
	localparam logic [KIND_W-1:0] KIND_FREE      = KIND_W'(1);
	localparam logic [KIND_W-1:0] KIND_CLEAR     = KIND_W'(2);
	localparam logic [KIND_W-1:0] KIND_NOP       = KIND_W'(3);
	localparam logic [KIND_W-1:0] KIND_TOO_LARGE = KIND_W'(4);

	localparam logic [STATUS_W-1:0] ST_OK         = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = STATUS_W'(2);
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = STATUS_W'(3);
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = STATUS_W'(4);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SIZE_W-1:0] need;
		logic [OFF_W-1:0]  offset;
	} cmd_t;

	typedef struct packed {
		logic [OFF_W-1:0]  offset;
		logic [SIZE_W-1:0] size;
		logic              in_use;
	} entry_t;

	typedef struct packed {
		logic                valid;
		logic [STATUS_W-1:0] status;
		logic [OFF_W-1:0]    offset;
		logic [SIZE_W-1:0]   used;
		logic [SIZE_W-1:0]   free;
	} result_t;

endpackage

`default_nettype wire

>>> hdl/btpa_front.sv
`default_nettype none

module btpa_front (
	input  wire logic                       start,
	input  wire logic [btpa_pkg::OP_W-1:0]  op,
	input  wire logic [btpa_pkg::SIZE_W-1:0] req_size,
	input  wire logic [btpa_pkg::OFF_W-1:0] free_offset,
	input  wire logic                       q_full,
	output logic                            busy,
	output logic                            push,
	output btpa_pkg::cmd_t                  push_cmd
);
	import btpa_pkg::*;

	logic [SIZE_W:0] sum;
	logic [SIZE_W:0] need;
	logic            too_large;

	// round up to the alignment, one bit wider so the largest request cannot wrap
	assign sum       = {1'b0, req_size} + (SIZE_W+1)'(ALIGN_BYTES - 1);
	assign need      = sum & ~((SIZE_W+1)'(ALIGN_BYTES - 1));
	assign too_large = need > (SIZE_W+1)'(POOL_BYTES);

	assign busy = q_full;
	assign push = start && !q_full;

	always_comb begin
		push_cmd.need   = need[SIZE_W-1:0];
		push_cmd.offset = free_offset;
		unique case (op)
			OP_ALLOC: push_cmd.kind = too_large ? KIND_TOO_LARGE : KIND_ALLOC;
			OP_FREE:  push_cmd.kind = KIND_FREE;
			OP_CLEAR: push_cmd.kind = KIND_CLEAR;
			default:  push_cmd.kind = KIND_NOP;
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/btpa_cmd_queue.sv
`default_nettype none
`include "assert_macros.svh"

module btpa_cmd_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire btpa_pkg::cmd_t push_cmd,
	input  wire logic           pop,
	output btpa_pkg::cmd_t      pop_cmd,
	output logic                full,
	output logic                empty
);
	import btpa_pkg::*;

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full    = cnt_q == QCNT_W'(QDEPTH);
	assign empty   = cnt_q == '0;
	assign pop_cmd = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`BTPA_ASSERT_NEVER(a_q_pop_empty, pop && empty, "command queue popped while empty")
	`BTPA_ASSERT_NEVER(a_q_push_full, push && full, "command queue pushed while full")
	`BTPA_ASSERT(a_q_cnt_range, cnt_q <= QCNT_W'(QDEPTH), "command queue count beyond depth")

endmodule

`default_nettype wire

>>> hdl/btpa_back.sv
`default_nettype none
`include "assert_macros.svh"

module btpa_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire btpa_pkg::cmd_t q_cmd,
	output logic                q_pop,
	output btpa_pkg::result_t   result
);
	import btpa_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	localparam logic [SIZE_W:0] POOL_EXT = (SIZE_W+1)'(POOL_BYTES);

	entry_t mem [MAX_BLOCKS];

	logic                state_q;
	cmd_t                cmd_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SIZE_W-1:0]   bump_q;
	logic [SIZE_W-1:0]   used_q;
	logic [CNT_W-1:0]    issue_q;
	logic                chk_valid_s1;
	logic [IDX_W-1:0]    chk_idx_s1;
	entry_t              rd_s1;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [OFF_W-1:0]    grant_q;

	logic            is_alloc;
	logic            issue;
	logic            alloc_hit;
	logic            free_hit;
	logic            hit;
	logic            scan_end;
	logic            tbl_full;
	logic            exhausted;
	logic            append;
	logic [SIZE_W:0] bump_sum;
	logic            we;
	logic [IDX_W-1:0] waddr;
	entry_t          wdata;

	assign is_alloc = cmd_q.kind == KIND_ALLOC;
	assign q_pop    = (state_q == S_IDLE) && !q_empty;

	// one table read issued per cycle during a scan, checked in the cycle after
	assign issue     = (state_q == S_SCAN) && (issue_q < cnt_q);
	assign alloc_hit = !rd_s1.in_use && (rd_s1.size >= cmd_q.need);
	assign free_hit  = rd_s1.offset == cmd_q.offset;
	assign hit       = (state_q == S_SCAN) && chk_valid_s1 && (is_alloc ? alloc_hit : free_hit);
	assign scan_end  = (state_q == S_SCAN) && !chk_valid_s1 && (issue_q >= cnt_q);

	assign bump_sum  = {1'b0, bump_q} + {1'b0, cmd_q.need};
	assign tbl_full  = cnt_q >= CNT_W'(MAX_BLOCKS);
	assign exhausted = ({1'b0, bump_q} >= POOL_EXT) || (bump_sum > POOL_EXT);
	assign append    = scan_end && is_alloc && !tbl_full && !exhausted;

	always_comb begin
		we    = 1'b0;
		waddr = chk_idx_s1;
		wdata = rd_s1;
		if (hit) begin
			we           = 1'b1;
			wdata.in_use = is_alloc;
		end else if (append) begin
			we           = 1'b1;
			waddr        = cnt_q[IDX_W-1:0];
			wdata.offset = bump_q[OFF_W-1:0];
			wdata.size   = cmd_q.need;
			wdata.in_use = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (issue) begin
			rd_s1      <= mem[issue_q[IDX_W-1:0]];
			chk_idx_s1 <= issue_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= '0;
			cnt_q        <= '0;
			bump_q       <= '0;
			used_q       <= '0;
			issue_q      <= '0;
			chk_valid_s1 <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= ST_OK;
			grant_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					chk_valid_s1 <= 1'b0;
					issue_q      <= '0;
					if (q_pop) begin
						cmd_q    <= q_cmd;
						status_q <= ST_OK;
						grant_q  <= '0;
						unique case (q_cmd.kind) inside
							KIND_ALLOC, KIND_FREE: begin
								state_q <= S_SCAN;
							end
							KIND_CLEAR: begin
								cnt_q  <= '0;
								bump_q <= '0;
								used_q <= '0;
								done_q <= 1'b1;
							end
							KIND_TOO_LARGE: begin
								status_q <= ST_TOO_LARGE;
								done_q   <= 1'b1;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (issue) begin
						issue_q <= issue_q + 1'b1;
					end
					chk_valid_s1 <= issue && !hit;
					if (hit) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						status_q <= ST_OK;
						if (is_alloc) begin
							grant_q <= rd_s1.offset;
							used_q  <= used_q + rd_s1.size;
						end else if (rd_s1.in_use) begin
							used_q <= used_q - rd_s1.size;
						end
					end else if (scan_end) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						if (!is_alloc) begin
							status_q <= ST_NOT_FOUND;
						end else if (tbl_full) begin
							status_q <= ST_TABLE_FULL;
						end else if (exhausted) begin
							status_q <= ST_EXHAUSTED;
						end else begin
							status_q <= ST_OK;
							grant_q  <= bump_q[OFF_W-1:0];
							cnt_q    <= cnt_q + 1'b1;
							bump_q   <= bump_sum[SIZE_W-1:0];
							used_q   <= used_q + cmd_q.need;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result.valid  = done_q;
	assign result.status = status_q;
	assign result.offset = grant_q;
	assign result.used   = used_q;
	assign result.free   = SIZE_W'(POOL_EXT - {1'b0, used_q});

	`BTPA_ASSERT(a_cnt_range, cnt_q <= CNT_W'(MAX_BLOCKS), "entry count beyond table size")
	`BTPA_ASSERT(a_bump_range, bump_q <= SIZE_W'(POOL_BYTES), "bump end beyond pool")
	`BTPA_ASSERT(a_used_le_bump, used_q <= bump_q, "used bytes exceed allocated span")
	`BTPA_ASSERT_NEVER(a_hit_and_end, hit && scan_end, "scan hit and scan end together")

endmodule

`default_nettype wire

>>> hdl/block_table_pool_allocator_core.sv
// First-fit pool allocator over a table of up to 32 blocks. A request is taken
// when start is high and busy is low; busy rises only when the two-entry command
// queue between the front end and the table engine is full. Each request yields
// exactly one result, shown for one cycle with done high; results come in request
// order and cannot be held off, so the receiver must take them when they appear.
// Reset-all, oversize and unknown requests raise done in the cycle after dequeue.
// Allocate and free scan the table one entry per cycle through its single read
// port and stop at the first match; the next request is dequeued only when the
// scan ends, so the scan sets the sustained rate. No clearing pass is needed
// after reset: the scan never reads past the entry count.
`default_nettype none

module block_table_pool_allocator_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [btpa_pkg::OP_W-1:0]      op,
	input  wire logic [btpa_pkg::SIZE_W-1:0]    req_size,
	input  wire logic [btpa_pkg::OFF_W-1:0]     free_offset,
	output logic                                done,
	output logic [btpa_pkg::STATUS_W-1:0]       status,
	output logic [btpa_pkg::OFF_W-1:0]          block_offset_out,
	output logic [btpa_pkg::SIZE_W-1:0]         used_bytes,
	output logic [btpa_pkg::SIZE_W-1:0]         free_bytes
);
	import btpa_pkg::*;

	logic    push;
	cmd_t    push_cmd;
	logic    q_full;
	logic    q_empty;
	logic    q_pop;
	cmd_t    q_cmd;
	result_t result;

	btpa_front u_front (
		.start       (start),
		.op          (op),
		.req_size    (req_size),
		.free_offset (free_offset),
		.q_full      (q_full),
		.busy        (busy),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	btpa_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.pop_cmd  (q_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	btpa_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop),
		.result  (result)
	);

	assign done             = result.valid;
	assign status           = result.status;
	assign block_offset_out = result.offset;
	assign used_bytes       = result.used;
	assign free_bytes       = result.free;

endmodule

`default_nettype wire
